@@ src/othb_pkg.sv @@
// Shared constants and types for the overwriting trace history buffer.
package othb_pkg;

    // Default sizing of the history ring
    localparam int DEPTH_DEF        = 64;
    localparam int RECORD_WIDTH_DEF = 64;

    // Fixed widths of the request and result fields
    localparam int KIND_W   = 2;
    localparam int DATA_W   = 64;
    localparam int LIMIT_W  = 7;
    localparam int CNT_W    = 64;

    // A single read never returns more than this many records
    localparam int MAX_RESULTS = 64;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Sequencer states
    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

@@ src/overwriting_trace_history_buffer.sv @@
// History ring of trace records that overwrites the oldest entry when full.
// Append and clear requests produce no result and leave busy low.
// A read returning N records (N >= 1) holds busy while it walks the ring and emits one record per
// cycle, each passing through the registered single read port of the record store.
// A read returning nothing emits one empty reply on the cycle after acceptance.
// Reset (synchronous, active low) clears positions, counters and flag; store contents stay.
module overwriting_trace_history_buffer #(
    parameter int DEPTH        = othb_pkg::DEPTH_DEF,
    parameter int RECORD_WIDTH = othb_pkg::RECORD_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [othb_pkg::KIND_W-1:0]  i_kind,
    input  logic [othb_pkg::DATA_W-1:0]  i_entry_data,
    input  logic [othb_pkg::LIMIT_W-1:0] i_read_limit,
    output logic                         o_strobe,
    output logic [othb_pkg::DATA_W-1:0]  o_record_out,
    output logic                         o_is_last,
    output logic                         o_empty_reply,
    output logic [othb_pkg::LIMIT_W-1:0] o_returned_count,
    output logic [othb_pkg::CNT_W-1:0]   o_total_seen,
    output logic [othb_pkg::CNT_W-1:0]   o_dropped_seen,
    output logic                         o_was_truncated
);
    import othb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int SW = WW + 1;

    localparam logic [AW-1:0]    LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0]    FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0]    DEPTH_S  = SW'(DEPTH);
    localparam logic [SW-1:0]    MAXRES_S = SW'(MAX_RESULTS);
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;

    // Record store
    logic [RECORD_WIDTH-1:0] r_mem [DEPTH];
    logic [RECORD_WIDTH-1:0] r_rd_data;

    // Control and status registers
    t_state              r_state, n_state;
    logic [AW-1:0]       r_wpos, n_wpos;
    logic [CW-1:0]       r_stored, n_stored;
    logic [CNT_W-1:0]    r_total, n_total;
    logic [CNT_W-1:0]    r_dropped, n_dropped;
    logic                r_trunc, n_trunc;
    logic [AW-1:0]       r_addr, n_addr;
    logic [LIMIT_W-1:0]  r_left, n_left;
    logic [LIMIT_W-1:0]  r_count, n_count;
    logic                r_out_strobe, n_out_strobe;
    logic                r_out_last, n_out_last;
    logic                r_out_empty, n_out_empty;

    logic                accept;
    logic                full;
    logic [SW-1:0]       stored_s, limit_s, clip1, clip2, start_sum, start_idx;
    logic [LIMIT_W-1:0]  rd_count;
    logic [AW-1:0]       rd_start;

    assign accept = start && !busy;
    assign full   = (r_stored == FULL_CNT);

    // Read length: min(limit, stored, MAX_RESULTS) and index of first record
    always_comb begin
        stored_s = SW'(r_stored);
        limit_s  = SW'(i_read_limit);
        clip1    = (stored_s < limit_s) ? stored_s : limit_s;
        clip2    = (clip1 < MAXRES_S) ? clip1 : MAXRES_S;
        rd_count = clip2[LIMIT_W-1:0];
        if (full) begin
            start_sum = SW'(r_wpos) + (DEPTH_S - clip2);
        end else begin
            start_sum = stored_s - clip2;
        end
        start_idx = (start_sum >= DEPTH_S) ? (start_sum - DEPTH_S) : start_sum;
        rd_start  = start_idx[AW-1:0];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_kind == KIND_READ && rd_count != '0) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_left == LIMIT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs of the sequencer
    always_comb begin
        busy         = (r_state == S_READ);
        n_wpos       = r_wpos;
        n_stored     = r_stored;
        n_total      = r_total;
        n_dropped    = r_dropped;
        n_trunc      = r_trunc;
        n_addr       = r_addr;
        n_left       = r_left;
        n_count      = r_count;
        n_out_strobe = 1'b0;
        n_out_last   = 1'b0;
        n_out_empty  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_APPEND: begin
                            n_wpos = (r_wpos == LAST_POS) ? '0 : r_wpos + AW'(1);
                            if (full) begin
                                n_trunc = 1'b1;
                                if (r_dropped != CNT_MAX) begin
                                    n_dropped = r_dropped + CNT_W'(1);
                                end
                            end else begin
                                n_stored = r_stored + CW'(1);
                            end
                            if (r_total != CNT_MAX) begin
                                n_total = r_total + CNT_W'(1);
                            end
                        end
                        KIND_READ: begin
                            n_count = rd_count;
                            if (rd_count == '0) begin
                                // nothing to return: one empty reply
                                n_out_strobe = 1'b1;
                                n_out_last   = 1'b1;
                                n_out_empty  = 1'b1;
                            end else begin
                                n_addr = rd_start;
                                n_left = rd_count;
                            end
                        end
                        KIND_CLEAR: begin
                            n_wpos    = '0;
                            n_stored  = '0;
                            n_total   = '0;
                            n_dropped = '0;
                            n_trunc   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                // one record read per cycle, walking the ring
                n_out_strobe = 1'b1;
                n_out_last   = (r_left == LIMIT_W'(1));
                n_left       = r_left - LIMIT_W'(1);
                n_addr       = (r_addr == LAST_POS) ? '0 : r_addr + AW'(1);
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wpos       <= '0;
            r_stored     <= '0;
            r_total      <= '0;
            r_dropped    <= '0;
            r_trunc      <= 1'b0;
            r_addr       <= '0;
            r_left       <= '0;
            r_count      <= '0;
            r_out_strobe <= 1'b0;
            r_out_last   <= 1'b0;
            r_out_empty  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wpos       <= n_wpos;
            r_stored     <= n_stored;
            r_total      <= n_total;
            r_dropped    <= n_dropped;
            r_trunc      <= n_trunc;
            r_addr       <= n_addr;
            r_left       <= n_left;
            r_count      <= n_count;
            r_out_strobe <= n_out_strobe;
            r_out_last   <= n_out_last;
            r_out_empty  <= n_out_empty;
        end
    end

    // Record store: write on append, registered read while streaming
    always_ff @(posedge i_clk) begin
        if (accept && r_state == S_IDLE && i_kind == KIND_APPEND) begin
            r_mem[r_wpos] <= i_entry_data[RECORD_WIDTH-1:0];
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Result ports
    assign o_strobe         = r_out_strobe;
    assign o_record_out     = r_out_empty ? '0 : DATA_W'(r_rd_data);
    assign o_is_last        = r_out_last;
    assign o_empty_reply    = r_out_empty;
    assign o_returned_count = r_count;
    assign o_total_seen     = r_total;
    assign o_dropped_seen   = r_dropped;
    assign o_was_truncated  = r_trunc;

endmodule
